@@ src/bis_pkg.sv @@
package bis_pkg;

  localparam int COORD_W    = 8;
  localparam int LCH_W      = 2;
  localparam int PIX_IN_W   = 16;
  localparam int POS_W      = 16;
  localparam int DIM_W      = 9;
  localparam int NCH_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int VAL_W      = 16;

  localparam logic [DIM_W-1:0] WIDTH_RST    = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST   = 9'd256;
  localparam logic [NCH_W-1:0] CHANNELS_RST = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = 2'd2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // neighbor order: top-left, top-right, bottom-left, bottom-right
  localparam logic [1:0] NB_00 = 2'd0;
  localparam logic [1:0] NB_01 = 2'd1;
  localparam logic [1:0] NB_10 = 2'd2;
  localparam logic [1:0] NB_11 = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_BASE,
    S_WRITE,
    S_READ,
    S_DRAIN1,
    S_DRAIN2,
    S_EMIT
  } bis_state_t;

  typedef struct packed {
    logic                req_type;
    logic [COORD_W-1:0]  load_col;
    logic [COORD_W-1:0]  load_row;
    logic [LCH_W-1:0]    load_channel;
    logic [PIX_IN_W-1:0] pixel_value;
    logic [POS_W-1:0]    sample_x;
    logic [POS_W-1:0]    sample_y;
  } bis_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic [1:0]       out_channel;
    logic             last_channel;
    logic             out_of_range;
  } bis_res_t;

  typedef struct packed {
    logic       latch;
    logic       calc;
    logic       base;
    logic       wr_en;
    logic       rd_en;
    logic [1:0] nb;
    logic [1:0] ch;
    logic       acc_clr;
    logic       emit;
    logic       last;
  } bis_cmd_t;

  typedef struct packed {
    logic             is_sample;
    logic             oor;
    logic [NCH_W-1:0] nch;
    logic             out_free;
  } bis_sts_t;

endpackage

@@ src/bis_if.sv @@
interface bis_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bis_pkg::COORD_W-1:0]   load_col;
  logic [bis_pkg::COORD_W-1:0]   load_row;
  logic [bis_pkg::LCH_W-1:0]     load_channel;
  logic [bis_pkg::PIX_IN_W-1:0]  pixel_value;
  logic [bis_pkg::POS_W-1:0]     sample_x;
  logic [bis_pkg::POS_W-1:0]     sample_y;

  modport source (
    output valid, req_type, load_col, load_row, load_channel, pixel_value,
           sample_x, sample_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, load_col, load_row, load_channel, pixel_value,
           sample_x, sample_y,
    output ready
  );
endinterface

interface bis_out_if;
  logic                       valid;
  logic                       ready;
  logic [bis_pkg::VAL_W-1:0]  sample_value;
  logic [1:0]                 out_channel;
  logic                       last_channel;
  logic                       out_of_range;

  modport source (
    output valid, sample_value, out_channel, last_channel, out_of_range,
    input  ready
  );
  modport sink (
    input  valid, sample_value, out_channel, last_channel, out_of_range,
    output ready
  );
endinterface

interface bis_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bis_pkg::CFG_IDX_W-1:0]    index;
  logic [bis_pkg::CFG_DATA_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ src/bilinear_image_sampler_core.sv @@
// Bilinear image sampler.
// in_chan: one transaction per request. req_type load writes one channel value of
//   one pixel into the on-chip image store; req_type sample gives an 8.8 (FRAC_BITS)
//   position and yields one out_chan transaction per channel in use, the final one
//   with last_channel set. Positions whose right or lower neighbor lies outside
//   the image return 0 with out_of_range set.
// cfg_chan: register writes (image_width, image_height, channels_in_use), always
//   ready; write only while no request is in flight.
// Sequence: a load is accepted, then passes the CALC and BASE address states and the
//   WRITE state; in_ready stays low until it returns to idle. A sample passes the
//   accepting cycle and the CALC and BASE address and weight setup states, then per
//   channel: four reads of the single-port pixel store, the DRAIN1 and DRAIN2 states
//   to drain the read/multiply/accumulate pipe, and loading of the output register.
//   An out-of-range sample skips the reads and goes from setup to loading the output
//   register for each channel. in_ready is high only between requests.
// Stalls: when out_chan.ready is low the result waits in the output register and
//   the sequencer holds until it is taken.
// Reset: registers return to 256 x 256 x 3 and the sequencer goes idle. The store
//   is not cleared; pixels must be loaded before they are sampled.
module bilinear_image_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bis_in_if.sink     in_chan,
  bis_out_if.source  out_chan,
  bis_cfg_if.sink    cfg_chan
);

  bis_pkg::bis_req_t req;
  bis_pkg::bis_res_t res;
  bis_pkg::bis_cmd_t cmd;
  bis_pkg::bis_sts_t sts;
  logic              in_ready;
  logic              res_valid;

  assign req.req_type     = in_chan.req_type;
  assign req.load_col     = in_chan.load_col;
  assign req.load_row     = in_chan.load_row;
  assign req.load_channel = in_chan.load_channel;
  assign req.pixel_value  = in_chan.pixel_value;
  assign req.sample_x     = in_chan.sample_x;
  assign req.sample_y     = in_chan.sample_y;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid        = res_valid;
  assign out_chan.sample_value = res.sample_value;
  assign out_chan.out_channel  = res.out_channel;
  assign out_chan.last_channel = res.last_channel;
  assign out_chan.out_of_range = res.out_of_range;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bis_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS),
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cfg_wr    (cfg_chan.valid),
    .cfg_idx   (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (out_chan.ready),
    .res       (res)
  );

endmodule

@@ src/bis_ctrl.sv @@
module bis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bis_pkg::bis_sts_t sts,
  output bis_pkg::bis_cmd_t cmd
);

  bis_pkg::bis_state_t state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [1:0] nb_r, nb_nxt;
  logic       last_ch;

  assign last_ch = ({1'b0, ch_r} + 3'd1) == sts.nch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bis_pkg::S_IDLE;
      ch_r    <= 2'd0;
      nb_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      nb_r    <= nb_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    nb_nxt    = nb_r;
    case (state_r)
      bis_pkg::S_IDLE: begin
        ch_nxt = 2'd0;
        if (in_valid) state_nxt = bis_pkg::S_CALC;
      end
      bis_pkg::S_CALC: state_nxt = bis_pkg::S_BASE;
      bis_pkg::S_BASE: begin
        nb_nxt = bis_pkg::NB_00;
        if (!sts.is_sample) state_nxt = bis_pkg::S_WRITE;
        else if (sts.oor)   state_nxt = bis_pkg::S_EMIT;
        else                state_nxt = bis_pkg::S_READ;
      end
      bis_pkg::S_WRITE: state_nxt = bis_pkg::S_IDLE;
      bis_pkg::S_READ: begin
        nb_nxt = nb_r + 2'd1;
        if (nb_r == bis_pkg::NB_11) state_nxt = bis_pkg::S_DRAIN1;
      end
      bis_pkg::S_DRAIN1: state_nxt = bis_pkg::S_DRAIN2;
      bis_pkg::S_DRAIN2: state_nxt = bis_pkg::S_EMIT;
      bis_pkg::S_EMIT: begin
        if (sts.out_free) begin
          if (last_ch) begin
            state_nxt = bis_pkg::S_IDLE;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            nb_nxt    = bis_pkg::NB_00;
            state_nxt = sts.oor ? bis_pkg::S_EMIT : bis_pkg::S_READ;
          end
        end
      end
      default: state_nxt = bis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    cmd.nb   = nb_r;
    in_ready = 1'b0;
    case (state_r)
      bis_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      bis_pkg::S_CALC:  cmd.calc  = 1'b1;
      bis_pkg::S_BASE:  cmd.base  = 1'b1;
      bis_pkg::S_WRITE: cmd.wr_en = 1'b1;
      bis_pkg::S_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.acc_clr = nb_r == bis_pkg::NB_00;
      end
      bis_pkg::S_DRAIN1, bis_pkg::S_DRAIN2: ;
      bis_pkg::S_EMIT: begin
        cmd.emit = sts.out_free;
        cmd.last = last_ch;
      end
      default: ;
    endcase
  end

endmodule

@@ src/bis_dp.sv @@
module bis_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CHANNELS   = 3,
  parameter int FRAC_BITS  = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bis_pkg::bis_req_t                 req,
  input  logic                              cfg_wr,
  input  logic [bis_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  bis_pkg::bis_cmd_t                 cmd,
  output bis_pkg::bis_sts_t                 sts,
  output logic                              res_valid,
  input  logic                              res_ready,
  output bis_pkg::bis_res_t                 res
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int A_W    = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int WT_W   = 2 * FRAC_BITS + 1;
  localparam int PR_W   = PIXEL_BITS + WT_W;
  localparam int ACC_W  = PIXEL_BITS + 2 * FRAC_BITS + 2;
  localparam int OFF_R  = CHANNELS;
  localparam int OFF_D  = MAX_WIDTH * CHANNELS;
  localparam int OFF_DR = OFF_D + CHANNELS;

  localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [ACC_W-1:0]   ROUND = ACC_W'(1) << (2 * FRAC_BITS - 1);

  logic [bis_pkg::DIM_W-1:0] width_r, height_r;
  logic [bis_pkg::NCH_W-1:0] chans_r;

  bis_pkg::bis_req_t req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [A_W-1:0]    base_r;
  logic              oor_r;
  logic              load_ok_r;
  logic [WT_W-1:0]   w00_r, w01_r, w10_r, w11_r;

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_r;
  logic [1:0]            nb_d_r;
  logic                  v1_r, v2_r;
  logic [PR_W-1:0]       prod_r;
  logic [ACC_W-1:0]      acc_r;

  logic                   out_valid_r;
  bis_pkg::bis_res_t      res_r;

  logic [bis_pkg::POS_W-1:0] x0, y0, row_sel, col_sel;
  logic [FRAC_BITS-1:0]      xf, yf;
  logic [FRAC_BITS:0]        sxf, syf;
  logic [31:0]               w_eff, h_eff;
  logic                      is_sample;
  logic [A_W-1:0]            rd_addr, wr_addr, nb_off;
  logic [WT_W-1:0]           w_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bis_pkg::WIDTH_RST;
      height_r <= bis_pkg::HEIGHT_RST;
      chans_r  <= bis_pkg::CHANNELS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bis_pkg::REG_IMAGE_WIDTH:     width_r  <= cfg_data;
        bis_pkg::REG_IMAGE_HEIGHT:    height_r <= cfg_data;
        bis_pkg::REG_CHANNELS_IN_USE: chans_r  <= cfg_data[bis_pkg::NCH_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_sample = req_r.req_type == bis_pkg::REQ_SAMPLE;
  assign x0  = req_r.sample_x >> FRAC_BITS;
  assign y0  = req_r.sample_y >> FRAC_BITS;
  assign xf  = req_r.sample_x[FRAC_BITS-1:0];
  assign yf  = req_r.sample_y[FRAC_BITS-1:0];
  assign sxf = ONE_F - {1'b0, xf};
  assign syf = ONE_F - {1'b0, yf};
  assign row_sel = is_sample ? y0 : bis_pkg::POS_W'(req_r.load_row);
  assign col_sel = is_sample ? x0 : bis_pkg::POS_W'(req_r.load_col);
  assign w_eff = (32'(width_r) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_r);
  assign h_eff = (32'(height_r) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) req_r <= req;
    if (cmd.calc) begin
      idx_r     <= IDX_W'(32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_sel));
      oor_r     <= (32'(x0) + 32'd1 >= w_eff) || (32'(y0) + 32'd1 >= h_eff);
      load_ok_r <= (32'(req_r.load_col) < 32'(MAX_WIDTH)) &&
                   (32'(req_r.load_row) < 32'(MAX_HEIGHT)) &&
                   (32'(req_r.load_channel) < 32'(CHANNELS));
      w00_r     <= WT_W'(sxf) * WT_W'(syf);
      w01_r     <= WT_W'(xf)  * WT_W'(syf);
      w10_r     <= WT_W'(sxf) * WT_W'(yf);
      w11_r     <= WT_W'(xf)  * WT_W'(yf);
    end
    if (cmd.base) base_r <= A_W'(32'(idx_r) * 32'(CHANNELS));
  end

  always_comb begin
    case (cmd.nb)
      bis_pkg::NB_00: nb_off = '0;
      bis_pkg::NB_01: nb_off = A_W'(OFF_R);
      bis_pkg::NB_10: nb_off = A_W'(OFF_D);
      bis_pkg::NB_11: nb_off = A_W'(OFF_DR);
      default:        nb_off = '0;
    endcase
  end

  assign rd_addr = base_r + A_W'(cmd.ch) + nb_off;
  assign wr_addr = base_r + A_W'(req_r.load_channel);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && load_ok_r) mem[wr_addr] <= PIXEL_BITS'(req_r.pixel_value);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
    nb_d_r <= cmd.nb;
  end

  always_comb begin
    case (nb_d_r)
      bis_pkg::NB_00: w_sel = w00_r;
      bis_pkg::NB_01: w_sel = w01_r;
      bis_pkg::NB_10: w_sel = w10_r;
      bis_pkg::NB_11: w_sel = w11_r;
      default:        w_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PR_W'(rdata_r) * PR_W'(w_sel);
    if (cmd.acc_clr)  acc_r <= ROUND;
    else if (v2_r)    acc_r <= acc_r + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_r.sample_value <= oor_r ? '0 : bis_pkg::VAL_W'(acc_r >> (2 * FRAC_BITS));
      res_r.out_channel  <= cmd.ch;
      res_r.last_channel <= cmd.last;
      res_r.out_of_range <= oor_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    sts.is_sample = is_sample;
    sts.oor       = oor_r;
    sts.out_free  = !out_valid_r || res_ready;
    if (chans_r == '0) begin
      sts.nch = 3'd1;
    end else if (32'(chans_r) > 32'(CHANNELS)) begin
      sts.nch = bis_pkg::NCH_W'(CHANNELS);
    end else begin
      sts.nch = chans_r;
    end
  end

endmodule
